[rtl/pftd_pkg.sv]
// ----------------------------------------------------------------------------
// Prime factoriser package
// Widths, codes and the command/status bundles shared by the controller,
// the datapath and the top level.
// ----------------------------------------------------------------------------
package pftd_pkg;

  // Field widths
  localparam int unsigned VAL_W    = 31;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned ADDR_W   = 3;

  // Trial divisor never passes 46342 and its square stays below 2^32
  localparam int unsigned DIV_W = 16;
  localparam int unsigned SQ_W  = 32;

  // Defaults for the top-level parameters
  localparam int unsigned MAX_FACTORS_DEF = 25;
  localparam int unsigned STORE_DEPTH_DEF = 32;

  localparam logic [VAL_W-1:0] LIMIT_RESET = 31'd99999999;

  // Register word indexes on the configuration port
  localparam logic REG_VALUE_LIMIT = 1'b0;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_OVER     = 2'd1,
    ST_TOO_MANY = 2'd2
  } status_e;

  // Controller states
  typedef enum logic [3:0] {
    S_IDLE,
    S_LOW,
    S_OVER,
    S_HALVE,
    S_CHECK,
    S_DIV,
    S_FINAL,
    S_JUDGE,
    S_MANY,
    S_READ,
    S_LOAD
  } state_e;

  // Source of the next remaining value
  typedef enum logic [1:0] {
    REM_HOLD,
    REM_IN,
    REM_HALF,
    REM_QUO
  } rem_sel_e;

  // Source of a factor written to the store
  typedef enum logic [1:0] {
    PUSH_TWO,
    PUSH_DIV,
    PUSH_REM
  } push_sel_e;

  // Source of the result factor
  typedef enum logic [1:0] {
    OSEL_REM,
    OSEL_MEM,
    OSEL_ZERO
  } out_sel_e;

  // Controller to datapath
  typedef struct packed {
    logic      load_in;
    rem_sel_e  rem_sel;
    logic      push;
    push_sel_e push_sel;
    logic      start_div;
    logic      next_div;
    logic      clr_rd;
    logic      rd_en;
    logic      rd_inc;
    logic      out_load;
    out_sel_e  out_sel;
    status_e   out_status;
    logic      out_last;
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic in_low;
    logic in_over;
    logic rem_even;
    logic rem_gt1;
    logic sq_le_rem;
    logic div_done;
    logic div_exact;
    logic count_many;
    logic out_free;
    logic send_last;
  } dp_stat_t;

endpackage

[rtl/pftd_div.sv]
// ----------------------------------------------------------------------------
// Restoring divider
// Unsigned VAL_W-bit division, one quotient bit per cycle. done_o rises
// once the last quotient bit is in and holds until the next start.
// ----------------------------------------------------------------------------
module pftd_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [pftd_pkg::VAL_W-1:0] dividend_i,
  input  logic [pftd_pkg::VAL_W-1:0] divisor_i,
  output logic                       done_o,
  output logic [pftd_pkg::VAL_W-1:0] quotient_o,
  output logic [pftd_pkg::VAL_W-1:0] remainder_o
);
  import pftd_pkg::*;

  localparam int unsigned CNT_W = $clog2(VAL_W);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [VAL_W-1:0] rem_q, rem_d;
  logic [VAL_W-1:0] quo_q, quo_d;
  logic [VAL_W-1:0] dvs_q, dvs_d;
  logic [VAL_W:0]   trial;
  logic             ge;

  // One restoring step: shift in the next dividend bit, subtract if it fits
  assign trial = {rem_q, quo_q[VAL_W-1]};
  assign ge    = trial >= {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = done_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      done_d = 1'b0;
      cnt_d  = CNT_W'(VAL_W - 1);
      rem_d  = '0;
      quo_d  = dividend_i;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      quo_d = {quo_q[VAL_W-2:0], ge};
      rem_d = ge ? VAL_W'(trial - {1'b0, dvs_q}) : trial[VAL_W-1:0];
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Operands and partial results
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign done_o      = done_q;
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

endmodule

[rtl/pftd_dp.sv]
// ----------------------------------------------------------------------------
// Prime factoriser datapath
// Remaining value, trial divisor and its square, the factor store, the
// divider and the result register, all steered by the controller.
// ----------------------------------------------------------------------------
module pftd_dp #(
  parameter int unsigned MAX_FACTORS = pftd_pkg::MAX_FACTORS_DEF,
  parameter int unsigned STORE_DEPTH = pftd_pkg::STORE_DEPTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  pftd_pkg::ctrl_cmd_t           cmd_i,
  output pftd_pkg::dp_stat_t            stat_o,
  input  logic [pftd_pkg::VAL_W-1:0]    value_i,
  input  logic [pftd_pkg::VAL_W-1:0]    limit_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [pftd_pkg::VAL_W-1:0]    factor_o,
  output logic [pftd_pkg::STATUS_W-1:0] status_o,
  output logic                          last_o
);
  import pftd_pkg::*;

  localparam int unsigned IDX_W = $clog2(STORE_DEPTH);
  localparam int unsigned CNT_W = IDX_W + 1;

  logic [VAL_W-1:0] rem_q, rem_d;
  logic [DIV_W-1:0] dvr_q, dvr_d;
  logic [SQ_W-1:0]  sq_q, sq_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] rd_q, rd_d;
  logic [CNT_W-1:0] rd_next;
  logic             out_valid_q, out_valid_d;
  logic [VAL_W-1:0] factor_q;
  status_e          status_q;
  logic             last_q;

  logic [VAL_W-1:0] mem_q [STORE_DEPTH];
  logic [VAL_W-1:0] rd_data_q;
  logic [VAL_W-1:0] push_data;
  logic             push_ok;

  logic [VAL_W-1:0] div_dividend;
  logic             div_done;
  logic [VAL_W-1:0] div_quo;
  logic [VAL_W-1:0] div_rem;

  // Shared divider
  assign div_dividend = (cmd_i.rem_sel == REM_QUO) ? div_quo : rem_q;

  pftd_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (cmd_i.start_div),
    .dividend_i  (div_dividend),
    .divisor_i   (VAL_W'(dvr_q)),
    .done_o      (div_done),
    .quotient_o  (div_quo),
    .remainder_o (div_rem)
  );

  // Factor to store
  always_comb begin
    case (cmd_i.push_sel)
      PUSH_TWO: push_data = VAL_W'(2);
      PUSH_DIV: push_data = VAL_W'(dvr_q);
      default:  push_data = rem_q;
    endcase
  end

  assign push_ok = cmd_i.push && (count_q < CNT_W'(STORE_DEPTH));
  assign rd_next = rd_q + 1'b1;

  // Working registers
  always_comb begin
    rem_d   = rem_q;
    dvr_d   = dvr_q;
    sq_d    = sq_q;
    count_d = count_q;
    rd_d    = rd_q;
    case (cmd_i.rem_sel)
      REM_IN:   rem_d = value_i;
      REM_HALF: rem_d = {1'b0, rem_q[VAL_W-1:1]};
      REM_QUO:  rem_d = div_quo;
      default:  rem_d = rem_q;
    endcase
    if (cmd_i.load_in) begin
      dvr_d   = DIV_W'(3);
      sq_d    = SQ_W'(9);
      count_d = '0;
    end
    if (cmd_i.next_div) begin
      // (d + 2)^2 = d^2 + 4d + 4
      dvr_d = dvr_q + DIV_W'(2);
      sq_d  = sq_q + SQ_W'({dvr_q, 2'b00}) + SQ_W'(4);
    end
    if (push_ok) begin
      count_d = count_q + 1'b1;
    end
    if (cmd_i.clr_rd) begin
      rd_d = '0;
    end else if (cmd_i.rd_inc) begin
      rd_d = rd_next;
    end
  end

  // Result register: holds a result while the receiver stalls
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q       <= '0;
      dvr_q       <= '0;
      sq_q        <= '0;
      count_q     <= '0;
      rd_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      rem_q       <= rem_d;
      dvr_q       <= dvr_d;
      sq_q        <= sq_d;
      count_q     <= count_d;
      rd_q        <= rd_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      case (cmd_i.out_sel)
        OSEL_REM: factor_q <= rem_q;
        OSEL_MEM: factor_q <= rd_data_q;
        default:  factor_q <= '0;
      endcase
      status_q <= cmd_i.out_status;
      last_q   <= cmd_i.out_last;
    end
  end

  // Factor store, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      mem_q[count_q[IDX_W-1:0]] <= push_data;
    end
    if (cmd_i.rd_en) begin
      rd_data_q <= mem_q[rd_q[IDX_W-1:0]];
    end
  end

  // Status to controller
  assign stat_o.in_low     = value_i < VAL_W'(2);
  assign stat_o.in_over    = value_i > limit_i;
  assign stat_o.rem_even   = ~rem_q[0];
  assign stat_o.rem_gt1    = rem_q > VAL_W'(1);
  assign stat_o.sq_le_rem  = sq_q <= SQ_W'(rem_q);
  assign stat_o.div_done   = div_done;
  assign stat_o.div_exact  = div_rem == '0;
  assign stat_o.count_many = count_q > CNT_W'(MAX_FACTORS);
  assign stat_o.out_free   = ~out_valid_q | out_ready_i;
  assign stat_o.send_last  = rd_next == count_q;

  assign out_valid_o = out_valid_q;
  assign factor_o    = factor_q;
  assign status_o    = status_q;
  assign last_o      = last_q;

endmodule

[rtl/pftd_ctrl.sv]
// ----------------------------------------------------------------------------
// Prime factoriser controller
// Sequences halving, trial division, the final remainder check, the
// read-out of the factor store and the single low/over/too-many results.
// ----------------------------------------------------------------------------
module pftd_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  pftd_pkg::dp_stat_t  stat_i,
  output pftd_pkg::ctrl_cmd_t cmd_o
);
  import pftd_pkg::*;

  state_e state_q, state_d;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (stat_i.in_low) begin
            state_d = S_LOW;
          end else if (stat_i.in_over) begin
            state_d = S_OVER;
          end else begin
            state_d = S_HALVE;
          end
        end
      end
      S_LOW, S_OVER, S_MANY: begin
        if (stat_i.out_free) state_d = S_IDLE;
      end
      S_HALVE: begin
        if (!stat_i.rem_even) state_d = S_CHECK;
      end
      S_CHECK: begin
        state_d = stat_i.sq_le_rem ? S_DIV : S_FINAL;
      end
      S_DIV: begin
        if (stat_i.div_done && !stat_i.div_exact) state_d = S_CHECK;
      end
      S_FINAL: state_d = S_JUDGE;
      S_JUDGE: state_d = stat_i.count_many ? S_MANY : S_READ;
      S_READ:  state_d = S_LOAD;
      S_LOAD: begin
        if (stat_i.out_free) state_d = stat_i.send_last ? S_IDLE : S_READ;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd_o            = '0;
    cmd_o.rem_sel    = REM_HOLD;
    cmd_o.push_sel   = PUSH_TWO;
    cmd_o.out_sel    = OSEL_ZERO;
    cmd_o.out_status = ST_OK;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          cmd_o.rem_sel = REM_IN;
        end
      end
      S_LOW: begin
        cmd_o.out_load = stat_i.out_free;
        cmd_o.out_sel  = OSEL_REM;
        cmd_o.out_last = 1'b1;
      end
      S_OVER: begin
        cmd_o.out_load   = stat_i.out_free;
        cmd_o.out_status = ST_OVER;
        cmd_o.out_last   = 1'b1;
      end
      S_MANY: begin
        cmd_o.out_load   = stat_i.out_free;
        cmd_o.out_status = ST_TOO_MANY;
        cmd_o.out_last   = 1'b1;
      end
      S_HALVE: begin
        if (stat_i.rem_even) begin
          cmd_o.push    = 1'b1;
          cmd_o.rem_sel = REM_HALF;
        end
      end
      S_CHECK: begin
        cmd_o.start_div = stat_i.sq_le_rem;
      end
      S_DIV: begin
        if (stat_i.div_done) begin
          if (stat_i.div_exact) begin
            // divide the same divisor into the quotient again
            cmd_o.push      = 1'b1;
            cmd_o.push_sel  = PUSH_DIV;
            cmd_o.rem_sel   = REM_QUO;
            cmd_o.start_div = 1'b1;
          end else begin
            cmd_o.next_div = 1'b1;
          end
        end
      end
      S_FINAL: begin
        cmd_o.push     = stat_i.rem_gt1;
        cmd_o.push_sel = PUSH_REM;
      end
      S_JUDGE: begin
        cmd_o.clr_rd = 1'b1;
      end
      S_READ: begin
        cmd_o.rd_en = 1'b1;
      end
      S_LOAD: begin
        cmd_o.out_load = stat_i.out_free;
        cmd_o.out_sel  = OSEL_MEM;
        cmd_o.out_last = stat_i.send_last;
        cmd_o.rd_inc   = stat_i.out_free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = state_q == S_IDLE;

endmodule

[rtl/prime_factorizer_trial_division.sv]
// ----------------------------------------------------------------------------
// Prime factoriser by trial division
// Splits a 31-bit value into its prime factors, ascending, with repeats.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid_i/in_ready_o carries value_i; output channel
//   out_valid_o/out_ready_i carries factor_o, status_o and last_o, with
//   last_o high on the final transfer of each value's run.
//   One value is worked on at a time; in_ready_o is high only while idle.
//   Values below 2 and values over value_limit give a single result,
//   loaded once the result register is free. Otherwise 2s are shifted
//   out one per cycle, then each odd trial divisor gets a check of its
//   square against the remainder and a pass through the restoring divider
//   (plus another pass per factor found), stopping once the divisor
//   squared exceeds the remainder. Factors then leave the store one at a
//   time, each read and then loaded into the result register. More than
//   MAX_FACTORS factors give a single too-many result.
//   The result register holds while out_ready_i is low and the work stalls
//   behind it; a new value is taken while the last result still waits.
//   Reset clears control state and sets value_limit to 99999999; the
//   factor store needs no clearing. value_limit sits at APB address 0.
// ----------------------------------------------------------------------------
module prime_factorizer_trial_division #(
  parameter int unsigned MAX_FACTORS = pftd_pkg::MAX_FACTORS_DEF,
  parameter int unsigned STORE_DEPTH = pftd_pkg::STORE_DEPTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Input channel
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [pftd_pkg::VAL_W-1:0]    value_i,
  // Output channel
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [pftd_pkg::VAL_W-1:0]    factor_o,
  output logic [pftd_pkg::STATUS_W-1:0] status_o,
  output logic                          last_o,
  // Configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [pftd_pkg::ADDR_W-1:0]   paddr,
  input  logic [pftd_pkg::DATA_W-1:0]   pwdata,
  output logic [pftd_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);
  import pftd_pkg::*;

  logic [VAL_W-1:0] limit_q, limit_d;
  logic             reg_idx;
  logic             wr_en;
  ctrl_cmd_t        cmd;
  dp_stat_t         stat;

  // Register file
  assign reg_idx = paddr[2];
  assign wr_en   = psel & penable & pwrite;

  always_comb begin
    limit_d = limit_q;
    prdata  = '0;
    unique case (reg_idx)
      REG_VALUE_LIMIT: begin
        prdata = DATA_W'(limit_q);
        if (wr_en) limit_d = pwdata[VAL_W-1:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LIMIT_RESET;
    end else begin
      limit_q <= limit_d;
    end
  end

  assign pready = 1'b1;

  pftd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  pftd_dp #(
    .MAX_FACTORS (MAX_FACTORS),
    .STORE_DEPTH (STORE_DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .value_i     (value_i),
    .limit_i     (limit_q),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .factor_o    (factor_o),
    .status_o    (status_o),
    .last_o      (last_o)
  );

endmodule
